// ===== src/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg
// Widths and constants shared by the vector normalizer files.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int ELEM_W      = 16;  // Q8.8 input component
  localparam int UNIT_W      = 16;  // Q1.14 output component
  localparam int QUOT_W      = 15;  // clamped quotient magnitude, 0..16384
  localparam int LEN_W       = 19;  // floor root of the square sum
  localparam int SUM_W       = 37;  // square sum, Q21.16
  localparam int SQ_W        = 31;  // one square, at most 2^30
  localparam int FRAC_SHIFT  = 14;  // Q1.14 scale
  localparam int DIVIDEND_W  = ELEM_W + FRAC_SHIFT;
  localparam int UNIT_ONE    = 16384;
  localparam int MAX_LEN_DEF = 64;

endpackage

// ===== src/vn_if.sv =====
// ----------------------------------------------------------------------------
// vn_if
// Valid/ready channels for input components and normalized results.
// ----------------------------------------------------------------------------
interface vn_in_if;
  import vn_pkg::*;

  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;
  logic              end_of_vector;

  modport source (output valid, element, end_of_vector, input ready);
  modport sink   (input valid, element, end_of_vector, output ready);
endinterface

interface vn_out_if;
  import vn_pkg::*;

  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] unit_component;
  logic [LEN_W-1:0]  vector_length;
  logic              zero_vector;
  logic              dropped;
  logic              final_result;

  modport source (output valid, unit_component, vector_length, zero_vector, dropped,
                  final_result, input ready);
  modport sink   (input valid, unit_component, vector_length, zero_vector, dropped,
                  final_result, output ready);
endinterface

// ===== src/vector_normalizer.sv =====
// ----------------------------------------------------------------------------
// vector_normalizer
// Euclidean normalization of a Q8.8 vector to Q1.14 unit components.
// ----------------------------------------------------------------------------
// Components arrive one word per cycle and are written to a component RAM
// while their squares accumulate into a 37-bit sum. The word flagged
// end_of_vector closes the vector: the block stops taking input, forms the
// magnitude with a two-bits-per-cycle square root, then reads each stored
// component back and divides it by the magnitude in a bit-serial divider.
// Results are truncated toward zero and clamped to +-1.0; each carries the
// magnitude and the flags. An all-zero vector yields zeros with zero_vector
// set. Components past MAX_LEN are discarded and every result of that vector
// has dropped set. The output register lets the block take the next vector's
// first word while the last result still waits.
// ----------------------------------------------------------------------------
module vector_normalizer #(
  parameter int MAX_LEN = vn_pkg::MAX_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  vn_in_if.sink    in_word,
  vn_out_if.source out_word
);
  import vn_pkg::*;

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  localparam logic [2:0] ST_LOAD  = 3'd0;  // taking components
  localparam logic [2:0] ST_SUM   = 3'd1;  // last square lands in the sum
  localparam logic [2:0] ST_START = 3'd2;  // launch root
  localparam logic [2:0] ST_ROOT  = 3'd3;  // wait for root
  localparam logic [2:0] ST_RD    = 3'd4;  // RAM read issued
  localparam logic [2:0] ST_CAP   = 3'd5;  // read data back, launch divide
  localparam logic [2:0] ST_DIV   = 3'd6;  // wait for quotient
  localparam logic [2:0] ST_PUSH  = 3'd7;  // hand result to output register

  logic [2:0]       state_r, state_nxt;
  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sq_r;
  logic             sq_v_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             ovf_r;
  logic [LEN_W-1:0] mag_r;
  logic             neg_r;
  logic [QUOT_W-1:0] q_r;

  logic              out_valid_r;
  logic [UNIT_W-1:0] out_unit_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_zero_r;
  logic              out_drop_r;
  logic              out_final_r;

  logic                     in_acc;
  logic                     store;
  logic signed [2*ELEM_W-1:0] sq_full;
  logic [ELEM_W-1:0]        rd_data;
  logic [ELEM_W-1:0]        abs_val;
  logic                     root_done;
  logic [LEN_W-1:0]         root;
  logic                     div_start;
  logic                     div_done;
  logic [QUOT_W-1:0]        div_q;
  logic                     zero_mag;
  logic                     push;
  logic                     is_final;
  logic [UNIT_W-1:0]        q_ext;

  // no words taken while reset is held
  assign in_word.ready = rst_n && (state_r == ST_LOAD);
  assign in_acc        = in_word.valid && in_word.ready;
  assign store         = in_acc && (count_r < CNT_W'(MAX_LEN));
  assign sq_full       = $signed(in_word.element) * $signed(in_word.element);
  assign zero_mag      = (mag_r == '0);
  // Two's complement magnitude; -32768 maps to 32768 in 16 unsigned bits.
  assign abs_val       = rd_data[ELEM_W-1] ? (~rd_data + 1'b1) : rd_data;
  assign div_start     = (state_r == ST_CAP) && !zero_mag;
  assign push          = (state_r == ST_PUSH) && (!out_valid_r || out_word.ready);
  assign is_final      = (CNT_W'(idx_r + 1'b1) == count_r);
  assign q_ext         = {{(UNIT_W-QUOT_W){1'b0}}, q_r};

  vn_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (store),
    .waddr   (count_r[AW-1:0]),
    .wdata   (in_word.element),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (rd_data)
  );

  vn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_START),
    .radicand (sum_r),
    .done_r   (root_done),
    .root     (root)
  );

  vn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .abs_val (abs_val),
    .mag     (mag_r),
    .done_r  (div_done),
    .quot    (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:  if (in_acc && in_word.end_of_vector) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_START;
      ST_START: state_nxt = ST_ROOT;
      ST_ROOT:  if (root_done) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_CAP;
      ST_CAP:   state_nxt = zero_mag ? ST_PUSH : ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_PUSH;
      ST_PUSH:  if (push) state_nxt = is_final ? ST_LOAD : ST_RD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      sum_r       <= '0;
      sq_v_r      <= 1'b0;
      count_r     <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sq_v_r  <= store;
      if (sq_v_r) begin
        sum_r <= sum_r + SUM_W'(sq_r);
      end
      if (store) begin
        count_r <= count_r + 1'b1;
      end else if (in_acc) begin
        ovf_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
        if (is_final) begin
          sum_r   <= '0;
          count_r <= '0;
          idx_r   <= '0;
          ovf_r   <= 1'b0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    sq_r <= sq_full[SQ_W-1:0];
    if (root_done) begin
      mag_r <= root;
    end
    if (state_r == ST_CAP) begin
      neg_r <= rd_data[ELEM_W-1];
      q_r   <= '0;
    end else if (state_r == ST_DIV && div_done) begin
      q_r <= div_q;
    end
    if (push) begin
      out_unit_r  <= neg_r ? (UNIT_W'(0) - q_ext) : q_ext;
      out_len_r   <= mag_r;
      out_zero_r  <= zero_mag;
      out_drop_r  <= ovf_r;
      out_final_r <= is_final;
    end
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.unit_component = out_unit_r;
  assign out_word.vector_length  = out_len_r;
  assign out_word.zero_vector    = out_zero_r;
  assign out_word.dropped        = out_drop_r;
  assign out_word.final_result   = out_final_r;

  // checks
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push && is_final |=> state_r == ST_LOAD && count_r == '0 && !ovf_r)
    else $error("vector state not cleared after final result");

  a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == ST_ROOT)
    else $error("root finished outside root wait");

  a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("quotient finished outside divide wait");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $signed(out_unit_r) <= $signed(UNIT_W'(UNIT_ONE)) &&
                    $signed(out_unit_r) >= -$signed(UNIT_W'(UNIT_ONE)))
    else $error("unit component beyond one");

endmodule

// ===== src/vn_ram.sv =====
// ----------------------------------------------------------------------------
// vn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== src/vn_isqrt.sv =====
// ----------------------------------------------------------------------------
// vn_isqrt
// Floor integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module vn_isqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [vn_pkg::SUM_W-1:0] radicand,
  output logic                     done_r,
  output logic [vn_pkg::LEN_W-1:0] root
);
  import vn_pkg::*;

  logic             busy_r;
  logic [SUM_W-1:0] x_r;
  logic [SUM_W:0]   root_r;
  logic [SUM_W-1:0] bit_r;
  logic [SUM_W:0]   trial;
  logic             take;

  assign trial = root_r + {1'b0, bit_r};
  assign take  = ({1'b0, x_r} >= trial);
  assign root  = root_r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && bit_r[0];
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      root_r <= '0;
      bit_r  <= {1'b1, {(SUM_W-1){1'b0}}};
    end else if (busy_r) begin
      if (take) begin
        x_r    <= x_r - trial[SUM_W-1:0];
        root_r <= (root_r >> 1) + {1'b0, bit_r};
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

// ===== src/vn_div.sv =====
// ----------------------------------------------------------------------------
// vn_div
// Restoring divider: (abs << 14) / mag, one quotient bit per cycle,
// result clamped to one in Q1.14.
// ----------------------------------------------------------------------------
module vn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [vn_pkg::ELEM_W-1:0] abs_val,
  input  logic [vn_pkg::LEN_W-1:0]  mag,
  output logic                      done_r,
  output logic [vn_pkg::QUOT_W-1:0] quot
);
  import vn_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [LEN_W-1:0]      rem_r;
  logic [LEN_W-1:0]      dvs_r;
  logic [LEN_W:0]        trial;
  logic                  take;
  logic                  last;

  assign trial = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign take  = (trial >= {1'b0, dvs_r});
  assign last  = (cnt_r == CNT_W'(DIVIDEND_W - 1));
  assign quot  = (quo_r > DIVIDEND_W'(UNIT_ONE)) ? QUOT_W'(UNIT_ONE) : quo_r[QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {abs_val, {FRAC_SHIFT{1'b0}}};
      dvs_r <= mag;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[DIVIDEND_W-2:0], take};
      rem_r <= take ? LEN_W'(trial - {1'b0, dvs_r}) : trial[LEN_W-1:0];
    end
  end

endmodule

// ===== tb/sv/vector_normalizer_check.sv =====
// ----------------------------------------------------------------------------
// vector_normalizer_check
// Watches both channels of the vector normalizer and checks each result word.
// ----------------------------------------------------------------------------
// Accepted input words within MAX_LEN update a private copy of the component
// store and square sum; the rest mark it dropped. On the word flagged
// end_of_vector one result per stored component is worked out and queued.
// Each accepted result word is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module vector_normalizer_check #(
  parameter int MAX_LEN = vn_pkg::MAX_LEN_DEF
) (
  input  logic clk,
  input  logic rst_n,
  vn_in_if     in_mon,
  vn_out_if    out_mon,
  output int   fail_count,
  output int   pending
);
  import vn_pkg::*;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_component;
    logic [LEN_W-1:0]  vector_length;
    logic              zero_vector;
    logic              dropped;
    logic              final_result;
  } unit_word_t;

  logic [ELEM_W-1:0] comp_mem [MAX_LEN];
  logic [SUM_W-1:0]  energy;
  int                held;
  logic              spilled;
  unit_word_t        owed_words[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Floor square root, one result bit at a time from the top.
  function automatic logic [LEN_W-1:0] floor_root(input logic [SUM_W-1:0] x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = LEN_W - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= 64'(x)) r = t;
    end
    return r[LEN_W-1:0];
  endfunction

  // Q8.8 component over Q11.8 magnitude, as Q1.14; truncates toward zero.
  function automatic logic [UNIT_W-1:0] scale_to_unit(input logic [ELEM_W-1:0] c,
                                                       input logic [LEN_W-1:0]  mag);
    int                v;
    longint unsigned   q;
    logic [UNIT_W-1:0] u;
    v = int'($signed(c));
    if (mag == '0) return '0;
    q = (longint'(v < 0 ? -v : v) << FRAC_SHIFT) / mag;
    if (q > UNIT_ONE) q = UNIT_ONE;
    u = q[UNIT_W-1:0];
    return (v < 0) ? -u : u;
  endfunction

  task automatic take_component(input logic [ELEM_W-1:0] c, input logic tail);
    logic [LEN_W-1:0] mag;
    longint           v;
    unit_word_t       w;
    v = longint'($signed(c));
    if (held < MAX_LEN) begin
      comp_mem[held] = c;
      energy = energy + SUM_W'(v * v);
      held++;
    end else begin
      spilled = 1'b1;
    end
    if (tail) begin
      mag = floor_root(energy);
      for (int k = 0; k < held; k++) begin
        w.unit_component = scale_to_unit(comp_mem[k], mag);
        w.vector_length  = mag;
        w.zero_vector    = (mag == '0);
        w.dropped        = spilled;
        w.final_result   = (k == held - 1);
        owed_words.push_back(w);
      end
      energy  = '0;
      held    = 0;
      spilled = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    fail_count++;
    $display("%0t vector_normalizer: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_word();
    unit_word_t w;
    if (owed_words.size() == 0) begin
      report_mismatch("result word with none owed, unit_component",
                      out_mon.unit_component, 0);
    end else begin
      w = owed_words.pop_front();
      if (out_mon.unit_component !== w.unit_component)
        report_mismatch("unit_component", out_mon.unit_component, w.unit_component);
      if (out_mon.vector_length !== w.vector_length)
        report_mismatch("vector_length", out_mon.vector_length, w.vector_length);
      if (out_mon.zero_vector !== w.zero_vector)
        report_mismatch("zero_vector", out_mon.zero_vector, w.zero_vector);
      if (out_mon.dropped !== w.dropped)
        report_mismatch("dropped", out_mon.dropped, w.dropped);
      if (out_mon.final_result !== w.final_result)
        report_mismatch("final_result", out_mon.final_result, w.final_result);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_words.delete();
      energy  = '0;
      held    = 0;
      spilled = 1'b0;
      pending <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        take_component(in_mon.element, in_mon.end_of_vector);
      if (out_mon.valid && out_mon.ready)
        check_word();
      pending <= owed_words.size();
    end
  end

endmodule

// ===== tb/sv/vector_normalizer_test.sv =====
// ----------------------------------------------------------------------------
// vector_normalizer_test
// Stimulus and verdict for the vector normalizer.
// ----------------------------------------------------------------------------
// Sends a short directed set of vectors (zero vectors, full-scale components,
// sign and truncation corners), then random vectors of mostly small length
// with a few that run past MAX_LEN. Both channels idle at random except for
// one calm stretch. A side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module vector_normalizer_test;
  import vn_pkg::*;

  localparam int VEC_MAX   = MAX_LEN_DEF;
  localparam int ITEM_GOAL = 280;  // random input words to send
  localparam int IDLE_PCT  = 23;   // idle odds per cycle on either side
  localparam int TAIL_CYC  = 100;  // quiet time after the last result word

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   calm  = 1'b0;  // set during the stretch with no idling at all

  int mismatches;
  int words_owed;      // result words still expected, as last registered by the checker
  int random_sent;

  vn_in_if  in_word ();
  vn_out_if out_word ();

  vector_normalizer #(
    .MAX_LEN (VEC_MAX)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  vector_normalizer_check #(
    .MAX_LEN (VEC_MAX)
  ) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_word),
    .out_mon    (out_word),
    .fail_count (mismatches),
    .pending    (words_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #800000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: ready drops at random, except in the calm stretch.
  initial out_word.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_word.ready <= 1'b0;
    end else begin
      out_word.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // One input word; valid stays high afterwards so back-to-back words
  // need no extra drive in the handshake step.
  task automatic send_component(input logic [ELEM_W-1:0] elem, input logic tail);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid         <= 1'b1;
    in_word.element       <= elem;
    in_word.end_of_vector <= tail;
    do @(posedge clk); while (!in_word.ready);
  endtask

  // Sender stops until the checker owes nothing. The extra edge lets the
  // owed count catch the vector closed at the handshake edge.
  task automatic hold_until_drained();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
  endtask

  // Mix of extremes, zero, small values and full-range noise.
  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(9)) inside
      0:       return '0;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3, 4:    return ELEM_W'($urandom_range(512) - 256);
      default: return ELEM_W'($urandom());
    endcase
  endfunction

  task automatic send_vector(input int len, input bit all_zero);
    for (int i = 0; i < len; i++) begin
      send_component(all_zero ? '0 : pick_element(), i == len - 1);
      random_sent++;
    end
  endtask

  initial begin
    int len;
    int sel;
    int vec_idx;

    in_word.valid         = 1'b0;
    in_word.element       = '0;
    in_word.end_of_vector = 1'b0;
    random_sent           = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    send_component(16'h0000, 1'b1);  // single zero: zero vector flag
    send_component(16'h7FFF, 1'b1);  // largest positive, unit +1.0
    send_component(16'h8000, 1'b1);  // most negative, unit -1.0
    send_component(16'h0300, 1'b0);  // 3, -4: magnitude 5.0
    send_component(16'hFC00, 1'b1);
    send_component(16'h0000, 1'b0);  // longer all-zero vector
    send_component(16'h0000, 1'b0);
    send_component(16'h0000, 1'b1);
    send_component(16'h0001, 1'b1);  // smallest magnitude 1 LSB
    send_component(16'hFFFF, 1'b1);  // -1 LSB alone
    send_component(16'h8000, 1'b0);  // both extremes together
    send_component(16'h7FFF, 1'b1);
    send_component(16'h0001, 1'b0);  // tiny beside huge: quotient to zero
    send_component(16'h7FFF, 1'b1);
    send_component(16'hFFFF, 1'b0);  // negative truncation toward zero
    send_component(16'h7FFF, 1'b1);

    // Pause the sender with results still coming out.
    hold_until_drained();

    // --- random part ---
    // The first random vector runs past MAX_LEN so the drop path and an
    // end_of_vector on a dropped word are always covered.
    vec_idx = 0;
    while (random_sent < ITEM_GOAL) begin
      calm = (random_sent >= 100) && (random_sent < 180);
      sel  = $urandom_range(99);
      if (vec_idx == 0)
        len = VEC_MAX + 2;
      else if (sel < 5)
        len = $urandom_range(VEC_MAX + 6, VEC_MAX - 2);
      else if (sel < 25)
        len = $urandom_range(24, 9);
      else
        len = $urandom_range(8, 1);
      send_vector(len, $urandom_range(11) == 0);
      if (vec_idx == 12)
        hold_until_drained();
      vec_idx++;
    end
    calm = 1'b0;

    // Wind down: drain what is owed, then watch for stray words.
    hold_until_drained();
    repeat (TAIL_CYC) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/vn_pkg.sv
src/vn_if.sv
src/vn_ram.sv
src/vn_isqrt.sv
src/vn_div.sv
src/vector_normalizer.sv
tb/sv/vector_normalizer_check.sv
tb/sv/vector_normalizer_test.sv
